// File: design/biquad_bandpass_filter_defines.svh
// Assertion macros for the biquad filter RTL.
// Used by biquad_bandpass_filter.sv; expects clk_i and rst_ni in scope.
`ifndef BIQUAD_BANDPASS_FILTER_DEFINES_SVH
`define BIQUAD_BANDPASS_FILTER_DEFINES_SVH

`ifndef SYNTHESIS
// checked property, disabled while reset is asserted
`define BBF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked property that also holds during reset
`define BBF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define BBF_ASSERT(name, prop, msg)
`define BBF_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// File: design/bbf_pkg.sv
// Package for the biquad filter: microcode word types, register indexes and
// the control store. No dependencies.
`default_nettype none

package bbf_pkg;

  localparam int unsigned ACC_W     = 64;          // accumulator, wraps mod 2^64
  localparam int unsigned HALF_W    = ACC_W / 2;
  localparam int unsigned MUL_W     = HALF_W + 1;  // signed operand width
  localparam int unsigned STEP_W    = 4;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [STEP_W-1:0] FIRST_STEP = 4'd0;
  localparam logic [STEP_W-1:0] LAST_STEP  = 4'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0   = 3'd0,
    REG_B1   = 3'd1,
    REG_B2   = 3'd2,
    REG_A1   = 3'd3,
    REG_A2   = 3'd4,
    REG_GAIN = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    SA_B0, SA_B1, SA_B2, SA_A1, SA_A2, SA_GAIN
  } sel_a_e;

  typedef enum logic [2:0] {
    SB_X_IN, SB_X1, SB_X2, SB_Y1, SB_Y2, SB_ACC_LO, SB_ACC_HI
  } sel_b_e;

  typedef enum logic [2:0] {
    ACC_NOP, ACC_LOAD, ACC_ADD, ACC_ADD_HI, ACC_SUB, ACC_ROUND
  } acc_op_e;

  typedef enum logic [1:0] {
    BR_NEXT,     // fall through to next step
    BR_WAIT_IN,  // hold until an input beat is taken
    BR_DONE      // hold until output register is free, then jump to start
  } branch_e;

  typedef struct packed {
    sel_a_e  sel_a;
    sel_b_e  sel_b;
    acc_op_e acc_op;
    branch_e br;
  } uc_word_t;

  // Control store. The multiplier result is registered, so an accumulator
  // op always consumes the product issued one step earlier.
  function automatic uc_word_t uc_rom(logic [STEP_W-1:0] step);
    uc_word_t w;
    w = '{sel_a: SA_B0, sel_b: SB_X1, acc_op: ACC_NOP, br: BR_NEXT};
    case (step)
      4'd0:  w = '{sel_a: SA_B0,   sel_b: SB_X_IN,   acc_op: ACC_NOP,    br: BR_WAIT_IN};
      4'd1:  w = '{sel_a: SA_B1,   sel_b: SB_X1,     acc_op: ACC_LOAD,   br: BR_NEXT};
      4'd2:  w = '{sel_a: SA_B2,   sel_b: SB_X2,     acc_op: ACC_ADD,    br: BR_NEXT};
      4'd3:  w = '{sel_a: SA_B0,   sel_b: SB_X1,     acc_op: ACC_ADD,    br: BR_NEXT};
      4'd4:  w = '{sel_a: SA_GAIN, sel_b: SB_ACC_LO, acc_op: ACC_NOP,    br: BR_NEXT};
      4'd5:  w = '{sel_a: SA_GAIN, sel_b: SB_ACC_HI, acc_op: ACC_LOAD,   br: BR_NEXT};
      4'd6:  w = '{sel_a: SA_B0,   sel_b: SB_X1,     acc_op: ACC_ADD_HI, br: BR_NEXT};
      4'd7:  w = '{sel_a: SA_A1,   sel_b: SB_Y1,     acc_op: ACC_ROUND,  br: BR_NEXT};
      4'd8:  w = '{sel_a: SA_A2,   sel_b: SB_Y2,     acc_op: ACC_SUB,    br: BR_NEXT};
      4'd9:  w = '{sel_a: SA_B0,   sel_b: SB_X1,     acc_op: ACC_SUB,    br: BR_NEXT};
      4'd10: w = '{sel_a: SA_B0,   sel_b: SB_X1,     acc_op: ACC_NOP,    br: BR_DONE};
      default: w = '{sel_a: SA_B0, sel_b: SB_X1,     acc_op: ACC_NOP,    br: BR_DONE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: design/biquad_bandpass_filter.sv
// Biquad IIR filter, direct form I, run by a microcoded sequencer over one
// shared multiplier. Depends on bbf_pkg and biquad_bandpass_filter_defines.svh.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, sample_in_i) takes one signed
//   sample per beat; output channel (out_valid_o/out_ready_i) returns one
//   filtered sample (sample_out_o) with clipped_o set when it saturated.
//   Coefficients b0, b1, b2, a1, a2 (indexes 0..4) and the numerator gain
//   (index 5) are written through cfg_we_i/cfg_idx_i/cfg_wdata_i while idle;
//   other indexes are ignored.
//   Throughput: a new sample is taken only once the previous one has run
//   through the control program, as in_ready_o is high only on its first step.
//   The control program drives the single 33x33 multiplier:
//   three feedforward products, two partial products for the gain, two
//   feedback products, with rounding and saturation steps in between.
//   Reset clears the sample history, zeroes the coefficients and sets the
//   gain to 1.0; the block is ready for input right after reset.
//   Stall: the finished sample sits in the output register. The next sample
//   is accepted and computed meanwhile, and the sequencer holds on its last
//   step until the output register frees up.
`default_nettype none
`include "biquad_bandpass_filter_defines.svh"

module biquad_bandpass_filter #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COEF_WIDTH   = 24
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration
  input  wire logic                              cfg_we_i,
  input  wire logic [bbf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [COEF_WIDTH-1:0]             cfg_wdata_i,
  // input samples
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    sample_in_i,
  // output samples
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]         sample_out_o,
  output logic                                   clipped_o
);

  localparam int unsigned GAIN_W = COEF_WIDTH - 1;
  localparam int unsigned FRAC_W = COEF_WIDTH - 4;
  localparam int unsigned ACC_W  = bbf_pkg::ACC_W;
  localparam int unsigned HALF_W = bbf_pkg::HALF_W;
  localparam int unsigned MUL_W  = bbf_pkg::MUL_W;
  localparam int unsigned STEP_W = bbf_pkg::STEP_W;

  localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (FRAC_W - 1);
  localparam logic signed [ACC_W-1:0] S_MAX = (ACC_W'(1) << (SAMPLE_WIDTH - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] S_MIN = ~S_MAX;
  localparam logic [SAMPLE_WIDTH-1:0] OUT_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] OUT_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic [COEF_WIDTH-1:0] GAIN_RESET = COEF_WIDTH'(1) << FRAC_W;

  // configuration registers
  logic signed [COEF_WIDTH-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;
  logic [GAIN_W-1:0]            gain_q;

  // history and working registers
  logic signed [SAMPLE_WIDTH-1:0] x_q, x1_q, x2_q, y1_q, y2_q;
  logic [ACC_W-1:0]               acc_q, acc_d;
  logic [ACC_W-1:0]               prod_q;
  logic [STEP_W-1:0]              step_q, step_d;
  logic                           out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_sample_q;
  logic                           out_clip_q;

  bbf_pkg::uc_word_t uc;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic signed [ACC_W-1:0]   acc_rnd;
  logic                      sat_hi, sat_lo;
  logic signed [SAMPLE_WIDTH-1:0] y_sat;
  logic                      in_fire, out_load;

  assign uc = bbf_pkg::uc_rom(step_q);

  assign in_ready_o = (uc.br == bbf_pkg::BR_WAIT_IN);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_load   = (uc.br == bbf_pkg::BR_DONE) && (!out_valid_q || out_ready_i);

  // operand select
  always_comb begin
    case (uc.sel_a)
      bbf_pkg::SA_B0:   mul_a = {{(MUL_W-COEF_WIDTH){b0_q[COEF_WIDTH-1]}}, b0_q};
      bbf_pkg::SA_B1:   mul_a = {{(MUL_W-COEF_WIDTH){b1_q[COEF_WIDTH-1]}}, b1_q};
      bbf_pkg::SA_B2:   mul_a = {{(MUL_W-COEF_WIDTH){b2_q[COEF_WIDTH-1]}}, b2_q};
      bbf_pkg::SA_A1:   mul_a = {{(MUL_W-COEF_WIDTH){a1_q[COEF_WIDTH-1]}}, a1_q};
      bbf_pkg::SA_A2:   mul_a = {{(MUL_W-COEF_WIDTH){a2_q[COEF_WIDTH-1]}}, a2_q};
      bbf_pkg::SA_GAIN: mul_a = {{(MUL_W-GAIN_W){1'b0}}, gain_q};
      default:          mul_a = '0;
    endcase
    case (uc.sel_b)
      bbf_pkg::SB_X_IN:
        mul_b = {{(MUL_W-SAMPLE_WIDTH){sample_in_i[SAMPLE_WIDTH-1]}}, sample_in_i};
      bbf_pkg::SB_X1:     mul_b = {{(MUL_W-SAMPLE_WIDTH){x1_q[SAMPLE_WIDTH-1]}}, x1_q};
      bbf_pkg::SB_X2:     mul_b = {{(MUL_W-SAMPLE_WIDTH){x2_q[SAMPLE_WIDTH-1]}}, x2_q};
      bbf_pkg::SB_Y1:     mul_b = {{(MUL_W-SAMPLE_WIDTH){y1_q[SAMPLE_WIDTH-1]}}, y1_q};
      bbf_pkg::SB_Y2:     mul_b = {{(MUL_W-SAMPLE_WIDTH){y2_q[SAMPLE_WIDTH-1]}}, y2_q};
      // gain product is split into halves; unsigned halves suffice mod 2^64
      bbf_pkg::SB_ACC_LO: mul_b = {1'b0, acc_q[HALF_W-1:0]};
      bbf_pkg::SB_ACC_HI: mul_b = {1'b0, acc_q[ACC_W-1:HALF_W]};
      default:            mul_b = '0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // round half up, arithmetic shift back to the lower Q format
  assign acc_rnd = $signed(acc_q + RND_HALF) >>> FRAC_W;

  assign sat_hi = (acc_rnd > S_MAX);
  assign sat_lo = (acc_rnd < S_MIN);

  always_comb begin
    if (sat_hi) begin
      y_sat = $signed(OUT_MAX);
    end else if (sat_lo) begin
      y_sat = $signed(OUT_MIN);
    end else begin
      y_sat = acc_rnd[SAMPLE_WIDTH-1:0];
    end
  end

  always_comb begin
    case (uc.acc_op)
      bbf_pkg::ACC_LOAD:   acc_d = prod_q;
      bbf_pkg::ACC_ADD:    acc_d = acc_q + prod_q;
      bbf_pkg::ACC_ADD_HI: acc_d = acc_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};
      bbf_pkg::ACC_SUB:    acc_d = acc_q - prod_q;
      bbf_pkg::ACC_ROUND:  acc_d = acc_rnd;
      default:             acc_d = acc_q;
    endcase
  end

  always_comb begin
    case (uc.br)
      bbf_pkg::BR_NEXT:    step_d = STEP_W'(step_q + 1'b1);
      bbf_pkg::BR_WAIT_IN: step_d = in_fire ? STEP_W'(step_q + 1'b1) : step_q;
      bbf_pkg::BR_DONE:    step_d = out_load ? bbf_pkg::FIRST_STEP : step_q;
      default:             step_d = bbf_pkg::FIRST_STEP;
    endcase
  end

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p[ACC_W-1:0];
    acc_q  <= acc_d;
    if (in_fire) begin
      x_q <= sample_in_i;
    end
    if (out_load) begin
      out_sample_q <= y_sat;
      out_clip_q   <= sat_hi || sat_lo;
    end
  end

  // control, configuration and history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= bbf_pkg::FIRST_STEP;
      out_valid_q <= 1'b0;
      b0_q        <= '0;
      b1_q        <= '0;
      b2_q        <= '0;
      a1_q        <= '0;
      a2_q        <= '0;
      gain_q      <= GAIN_RESET[GAIN_W-1:0];
      x1_q        <= '0;
      x2_q        <= '0;
      y1_q        <= '0;
      y2_q        <= '0;
    end else begin
      step_q <= step_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
        x2_q        <= x1_q;
        x1_q        <= x_q;
        y2_q        <= y1_q;
        y1_q        <= y_sat;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bbf_pkg::REG_B0:   b0_q   <= cfg_wdata_i;
          bbf_pkg::REG_B1:   b1_q   <= cfg_wdata_i;
          bbf_pkg::REG_B2:   b2_q   <= cfg_wdata_i;
          bbf_pkg::REG_A1:   a1_q   <= cfg_wdata_i;
          bbf_pkg::REG_A2:   a2_q   <= cfg_wdata_i;
          bbf_pkg::REG_GAIN: gain_q <= cfg_wdata_i[GAIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;
  assign clipped_o    = out_clip_q;

  // an input beat always starts the program
  `BBF_ASSERT(a_start_after_in, in_valid_i && in_ready_o |=> step_q == STEP_W'(bbf_pkg::FIRST_STEP + 1'b1), "sequencer did not start after input beat")
  // a new result only appears after the last program step
  `BBF_ASSERT(a_out_from_last, $rose(out_valid_o) |-> $past(step_q) == bbf_pkg::LAST_STEP, "output valid without finishing the program")
  // a clipped result sits on one of the rails
  `BBF_ASSERT(a_clip_at_rail, out_valid_o && clipped_o |-> sample_out_o == OUT_MAX || sample_out_o == OUT_MIN, "clipped result not at full scale")
  // step counter never leaves the control store
  `BBF_ASSERT_ALWAYS(a_step_range, !rst_ni || step_q <= bbf_pkg::LAST_STEP, "step counter out of range")

endmodule

`default_nettype wire
